// ===== hw/rtl/pcb_pkg.sv =====
package pcb_pkg;

    localparam int unsigned MAX_SIDE   = 16;
    localparam int unsigned JACK_MAX   = 16;
    localparam int unsigned MAX_POINTS = 1048576;
    localparam int unsigned NCELLS     = MAX_SIDE * MAX_SIDE * MAX_SIDE;
    localparam int unsigned CELL_W     = $clog2(NCELLS);
    localparam int unsigned TOT_W      = 21;
    localparam int unsigned SLOT_W     = 20;
    localparam int unsigned SIDE_W     = 5;
    localparam int unsigned BIN_W      = 4;
    localparam int unsigned QUO_W      = 36;

    localparam logic [1:0] FUNC_CLEAR   = 2'd0;
    localparam logic [1:0] FUNC_COUNT   = 2'd1;
    localparam logic [1:0] FUNC_PREPARE = 2'd2;
    localparam logic [1:0] FUNC_INSERT  = 2'd3;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_SKIP = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;
    localparam logic [1:0] STAT_DONE = 2'd3;

    localparam logic [1:0] CFG_GRID_SIDE = 2'd0;
    localparam logic [1:0] CFG_JACK_SIDE = 2'd1;
    localparam logic [1:0] CFG_BOX_RECIP = 2'd2;

    typedef struct packed {
        logic              rd_en;
        logic [CELL_W-1:0] rd_addr;
        logic              tot_we;
        logic [CELL_W-1:0] tot_waddr;
        logic [TOT_W-1:0]  tot_wdata;
        logic              fill_we;
        logic [CELL_W-1:0] fill_waddr;
        logic [TOT_W-1:0]  fill_wdata;
        logic              base_we;
        logic [CELL_W-1:0] base_waddr;
        logic [SLOT_W-1:0] base_wdata;
    } mem_req_t;

    typedef struct packed {
        logic [TOT_W-1:0]  tot;
        logic [TOT_W-1:0]  fill;
        logic [SLOT_W-1:0] base;
    } mem_rsp_t;

endpackage

// ===== hw/rtl/particle_cell_binning.sv =====
// Count and insert: six bins, each one multiply, one scale and a remainder
// in the shared 4-bit-per-cycle unit, then a cell read-modify-write.
// Clear and prepare: one sweep over all 4096 cells.
// Throughput: one item at a time; in_stall stays high until the result is in the output register.
// Reset: a pass over all 4096 cells zeroes counts and fill counters; no item is taken meanwhile.
// Configuration registers reset to grid_side 8, jack_side 1, box_recip 65536.
module particle_cell_binning (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [31:0]                   cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    func,
    input  logic signed [31:0]            pos_x,
    input  logic signed [31:0]            pos_y,
    input  logic signed [31:0]            pos_z,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    status,
    output logic [pcb_pkg::CELL_W-1:0]    cell_index,
    output logic [pcb_pkg::SLOT_W-1:0]    slot,
    output logic [pcb_pkg::BIN_W-1:0]     jack_x,
    output logic [pcb_pkg::BIN_W-1:0]     jack_y,
    output logic [pcb_pkg::BIN_W-1:0]     jack_z
);
    import pcb_pkg::*;

    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_CLEAR  = 4'd2;
    localparam logic [3:0] S_NC1    = 4'd3;
    localparam logic [3:0] S_NC2    = 4'd4;
    localparam logic [3:0] S_PREP   = 4'd5;
    localparam logic [3:0] S_PDRAIN = 4'd6;
    localparam logic [3:0] S_MUL    = 4'd7;
    localparam logic [3:0] S_SCALE  = 4'd8;
    localparam logic [3:0] S_REM    = 4'd9;
    localparam logic [3:0] S_READ   = 4'd10;
    localparam logic [3:0] S_WRITE  = 4'd11;
    localparam logic [3:0] S_OUT    = 4'd12;

    localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(NCELLS - 1);

    logic [3:0]        state_reg, state_next;
    logic [SIDE_W-1:0] grid_side_reg, grid_side_next;
    logic [SIDE_W-1:0] jack_side_reg, jack_side_next;
    logic [31:0]       box_recip_reg, box_recip_next;
    logic [CELL_W-1:0] cnt_reg, cnt_next;
    logic [1:0]        func_reg, func_next;
    logic [30:0]       px_reg, px_next, py_reg, py_next, pz_reg, pz_next;
    logic [2:0]        pair_reg, pair_next;
    logic [62:0]       t_reg, t_next;
    logic [CELL_W-1:0] acc_reg, acc_next;
    logic [BIN_W-1:0]  jx_reg, jx_next, jy_reg, jy_next, jz_reg, jz_next;
    logic [8:0]        nsq_reg, nsq_next;
    logic [CELL_W:0]   ncell_reg, ncell_next;
    logic [TOT_W-1:0]  sum_reg, sum_next;
    logic              pv_reg, pv_next;
    logic [CELL_W-1:0] pa_reg, pa_next;
    logic [1:0]        res_status_reg, res_status_next;
    logic [CELL_W-1:0] res_cell_reg, res_cell_next;
    logic [SLOT_W-1:0] res_slot_reg, res_slot_next;
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        status_reg;
    logic [CELL_W-1:0] cell_index_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [BIN_W-1:0]  jack_x_reg, jack_y_reg, jack_z_reg;

    logic [SIDE_W-1:0] gside, jside, side_sel;
    logic [30:0]       pos_sel;
    logic [67:0]       scaled;
    logic              rem_start, rem_done;
    logic [BIN_W-1:0]  rem;
    logic              load_out;
    mem_req_t          req;
    mem_rsp_t          rsp;
    logic [TOT_W:0]    sum_wide;

    pcb_rem_unit u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (scaled[67:32]),
        .divisor  (side_sel),
        .done     (rem_done),
        .rem      (rem)
    );

    pcb_cell_store u_store (
        .clk (clk),
        .req (req),
        .rsp (rsp)
    );

    assign gside = (grid_side_reg == '0) ? SIDE_W'(1) :
                   (grid_side_reg > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : grid_side_reg;
    assign jside = (jack_side_reg == '0) ? SIDE_W'(1) :
                   (jack_side_reg > SIDE_W'(JACK_MAX)) ? SIDE_W'(JACK_MAX) : jack_side_reg;
    assign side_sel = (pair_reg < 3'd3) ? gside : jside;
    assign scaled   = {5'd0, t_reg} * 68'(side_sel);
    assign sum_wide = {1'b0, sum_reg} + {1'b0, rsp.tot};
    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign load_out  = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        case (pair_reg)
            3'd0, 3'd3: pos_sel = px_reg;
            3'd1, 3'd4: pos_sel = py_reg;
            default:    pos_sel = pz_reg;
        endcase
    end

    always_comb
    begin
        grid_side_next = grid_side_reg;
        jack_side_next = jack_side_reg;
        box_recip_next = box_recip_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_GRID_SIDE: grid_side_next = cfg_data[SIDE_W-1:0];
                CFG_JACK_SIDE: jack_side_next = cfg_data[SIDE_W-1:0];
                CFG_BOX_RECIP: box_recip_next = cfg_data;
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        func_next       = func_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        pz_next         = pz_reg;
        pair_next       = pair_reg;
        t_next          = t_reg;
        acc_next        = acc_reg;
        jx_next         = jx_reg;
        jy_next         = jy_reg;
        jz_next         = jz_reg;
        nsq_next        = nsq_reg;
        ncell_next      = ncell_reg;
        sum_next        = sum_reg;
        pv_next         = (state_reg == S_PREP);
        pa_next         = cnt_reg;
        res_status_next = res_status_reg;
        res_cell_next   = res_cell_reg;
        res_slot_next   = res_slot_reg;
        rem_start       = 1'b0;
        req             = '0;

        if (pv_reg)
        begin
            req.fill_we    = 1'b1;
            req.fill_waddr = pa_reg;
            if ({1'b0, pa_reg} < ncell_reg)
            begin
                req.base_we    = 1'b1;
                req.base_waddr = pa_reg;
                req.base_wdata = sum_reg[SLOT_W-1:0];
                sum_next = (sum_wide > (TOT_W+1)'(MAX_POINTS)) ?
                           TOT_W'(MAX_POINTS) : sum_wide[TOT_W-1:0];
            end
        end

        case (state_reg)
            S_INIT:
            begin
                req.tot_we     = 1'b1;
                req.tot_waddr  = cnt_reg;
                req.fill_we    = 1'b1;
                req.fill_waddr = cnt_reg;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_CELL)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next       = func;
                    px_next         = pos_x[30:0];
                    py_next         = pos_y[30:0];
                    pz_next         = pos_z[30:0];
                    cnt_next        = '0;
                    pair_next       = '0;
                    acc_next        = '0;
                    res_cell_next   = '0;
                    res_slot_next   = '0;
                    jx_next         = '0;
                    jy_next         = '0;
                    jz_next         = '0;
                    res_status_next = STAT_DONE;
                    case (func)
                        FUNC_CLEAR:   state_next = S_CLEAR;
                        FUNC_PREPARE: state_next = S_NC1;
                        default:
                        begin
                            if (pos_x[31] || pos_y[31] || pos_z[31])
                            begin
                                res_status_next = STAT_SKIP;
                                state_next      = S_OUT;
                            end
                            else
                            begin
                                state_next = S_MUL;
                            end
                        end
                    endcase
                end
            end
            S_CLEAR:
            begin
                req.tot_we    = 1'b1;
                req.tot_waddr = cnt_reg;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_CELL)
                begin
                    state_next = S_OUT;
                end
            end
            S_NC1:
            begin
                nsq_next   = 9'(gside) * 9'(gside);
                state_next = S_NC2;
            end
            S_NC2:
            begin
                ncell_next = (CELL_W+1)'(nsq_reg) * (CELL_W+1)'(gside);
                sum_next   = '0;
                state_next = S_PREP;
            end
            S_PREP:
            begin
                req.rd_en   = 1'b1;
                req.rd_addr = cnt_reg;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_CELL)
                begin
                    state_next = S_PDRAIN;
                end
            end
            S_PDRAIN:
            begin
                state_next = S_OUT;
            end
            S_MUL:
            begin
                t_next     = 63'(pos_sel) * 63'(box_recip_reg);
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                rem_start  = 1'b1;
                state_next = S_REM;
            end
            S_REM:
            begin
                if (rem_done)
                begin
                    case (pair_reg)
                        3'd3:    jx_next = rem;
                        3'd4:    jy_next = rem;
                        3'd5:    jz_next = rem;
                        default: acc_next = CELL_W'(acc_reg * gside) + CELL_W'(rem);
                    endcase
                    pair_next = pair_reg + 3'd1;
                    state_next = (pair_reg == 3'd5) ? S_READ : S_MUL;
                end
            end
            S_READ:
            begin
                req.rd_en     = 1'b1;
                req.rd_addr   = acc_reg;
                res_cell_next = acc_reg;
                state_next    = S_WRITE;
            end
            S_WRITE:
            begin
                res_status_next = STAT_OK;
                if (func_reg == FUNC_COUNT)
                begin
                    if (rsp.tot < TOT_W'(MAX_POINTS))
                    begin
                        req.tot_we    = 1'b1;
                        req.tot_waddr = acc_reg;
                        req.tot_wdata = rsp.tot + 1'b1;
                    end
                end
                else if (rsp.fill >= rsp.tot)
                begin
                    res_status_next = STAT_FULL;
                end
                else
                begin
                    res_slot_next   = rsp.base + rsp.fill[SLOT_W-1:0];
                    req.fill_we     = 1'b1;
                    req.fill_waddr  = acc_reg;
                    req.fill_wdata  = rsp.fill + 1'b1;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            cnt_reg       <= '0;
            pv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            grid_side_reg <= SIDE_W'(8);
            jack_side_reg <= SIDE_W'(1);
            box_recip_reg <= 32'd65536;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pv_reg        <= pv_next;
            out_valid_reg <= out_valid_next;
            grid_side_reg <= grid_side_next;
            jack_side_reg <= jack_side_next;
            box_recip_reg <= box_recip_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        px_reg         <= px_next;
        py_reg         <= py_next;
        pz_reg         <= pz_next;
        pair_reg       <= pair_next;
        t_reg          <= t_next;
        acc_reg        <= acc_next;
        jx_reg         <= jx_next;
        jy_reg         <= jy_next;
        jz_reg         <= jz_next;
        nsq_reg        <= nsq_next;
        ncell_reg      <= ncell_next;
        sum_reg        <= sum_next;
        pa_reg         <= pa_next;
        res_status_reg <= res_status_next;
        res_cell_reg   <= res_cell_next;
        res_slot_reg   <= res_slot_next;
        if (load_out)
        begin
            status_reg     <= res_status_reg;
            cell_index_reg <= res_cell_reg;
            slot_reg       <= res_slot_reg;
            jack_x_reg     <= jx_reg;
            jack_y_reg     <= jy_reg;
            jack_z_reg     <= jz_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign cell_index = cell_index_reg;
    assign slot       = slot_reg;
    assign jack_x     = jack_x_reg;
    assign jack_y     = jack_y_reg;
    assign jack_z     = jack_z_reg;

endmodule

// ===== hw/rtl/pcb_rem_unit.sv =====
module pcb_rem_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pcb_pkg::QUO_W-1:0]   dividend,
    input  logic [pcb_pkg::SIDE_W-1:0]  divisor,
    output logic                        done,
    output logic [pcb_pkg::BIN_W-1:0]   rem
);
    import pcb_pkg::*;

    localparam int unsigned STEPS = QUO_W / 4;

    logic [QUO_W-1:0] sh_reg, sh_next;
    logic [BIN_W-1:0] r_reg, r_next;
    logic [3:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    always_comb
    begin
        logic [BIN_W-1:0]  r;
        logic [SIDE_W-1:0] r5;
        r = r_reg;
        for (int i = 0; i < 4; i++)
        begin
            r5 = {r, sh_reg[QUO_W-1-i]};
            if (r5 >= divisor)
            begin
                r5 = r5 - divisor;
            end
            r = r5[BIN_W-1:0];
        end
        sh_next   = sh_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            sh_next   = dividend;
            r_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            sh_next  = sh_reg << 4;
            r_next   = r;
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'(STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg <= sh_next;
        r_reg  <= r_next;
    end

    assign done = done_reg;
    assign rem  = r_reg;

endmodule

// ===== hw/rtl/pcb_cell_store.sv =====
module pcb_cell_store (
    input  logic               clk,
    input  pcb_pkg::mem_req_t  req,
    output pcb_pkg::mem_rsp_t  rsp
);
    import pcb_pkg::*;

    logic [TOT_W-1:0]  tot_mem  [NCELLS];
    logic [TOT_W-1:0]  fill_mem [NCELLS];
    logic [SLOT_W-1:0] base_mem [NCELLS];
    mem_rsp_t          rsp_reg;

    always_ff @(posedge clk)
    begin
        if (req.tot_we)
        begin
            tot_mem[req.tot_waddr] <= req.tot_wdata;
        end
        if (req.fill_we)
        begin
            fill_mem[req.fill_waddr] <= req.fill_wdata;
        end
        if (req.base_we)
        begin
            base_mem[req.base_waddr] <= req.base_wdata;
        end
        if (req.rd_en)
        begin
            rsp_reg.tot  <= tot_mem[req.rd_addr];
            rsp_reg.fill <= fill_mem[req.rd_addr];
            rsp_reg.base <= base_mem[req.rd_addr];
        end
    end

    assign rsp = rsp_reg;

endmodule

// ===== hw/rtl/pcb_checker.sv =====
module pcb_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [1:0]                  status,
    input  logic [pcb_pkg::CELL_W-1:0]  cell_index,
    input  logic [pcb_pkg::SLOT_W-1:0]  slot,
    input  logic [pcb_pkg::BIN_W-1:0]   jack_x,
    input  logic [pcb_pkg::BIN_W-1:0]   jack_y,
    input  logic [pcb_pkg::BIN_W-1:0]   jack_z
);
    import pcb_pkg::*;

    a_hold_beat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output beat dropped while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again before item finished");

    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STAT_DONE || status == STAT_SKIP) |->
        cell_index == '0 && slot == '0 && jack_x == '0 && jack_y == '0 && jack_z == '0)
        else $error("command or skip result carries nonzero fields");

    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STAT_FULL |-> slot == '0)
        else $error("full cell reports a slot");

endmodule

bind particle_cell_binning pcb_checker u_pcb_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .cell_index (cell_index),
    .slot       (slot),
    .jack_x     (jack_x),
    .jack_y     (jack_y),
    .jack_z     (jack_z)
);
